// ----- rtl/tcpu_pkg.sv -----
// shared types and constants of the tiny cpu execute unit
package tcpu_pkg;

   localparam int DATA_W    = 16;
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;
   localparam int IMM_W     = 8;
   localparam int TARGET_W  = 12;
   localparam int SHAMT_W   = 4;
   // data memory depth, a power of two so the address is the low bits of a register
   localparam int MEM_WORDS  = 4096;
   localparam int MEM_ADDR_W = $clog2(MEM_WORDS);

   // instruction format in bits 1:0
   typedef enum logic [1:0] {
      FMT_ALU_REG = 2'd0,
      FMT_ALU_IMM = 2'd1,
      FMT_JUMP    = 2'd2,
      FMT_MEM     = 2'd3
   } fmt_type;

   // alu select in bits 4:2
   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_SUB = 3'd1,
      ALU_AND = 3'd2,
      ALU_OR  = 3'd3,
      ALU_XOR = 3'd4,
      ALU_SHL = 3'd5,
      ALU_SHR = 3'd6,
      ALU_CMP = 3'd7
   } alu_op_type;

   // compare outcomes
   localparam logic [DATA_W-1:0] CMP_EQ = DATA_W'(0);
   localparam logic [DATA_W-1:0] CMP_GT = DATA_W'(1);
   localparam logic [DATA_W-1:0] CMP_LT = DATA_W'(2);

   // register file write port
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    data;
   } rf_write_type;

endpackage

// ----- rtl/tcpu_ifs.sv -----
// valid/ready channel interfaces for instructions and results
interface tcpu_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcpu_pkg::DATA_W-1:0] instruction;

   modport source (output valid, output instruction, input ready);
   modport sink   (input valid, input instruction, output ready);
endinterface

interface tcpu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tcpu_pkg::DATA_W-1:0]    next_pc;
   logic                           reg_written;
   logic [tcpu_pkg::REG_IDX_W-1:0] dest_reg;
   logic [tcpu_pkg::DATA_W-1:0]    dest_value;
   logic                           jump_taken;
   logic                           memory_stored;

   modport source (output valid, output next_pc, output reg_written, output dest_reg,
                   output dest_value, output jump_taken, output memory_stored,
                   input ready);
   modport sink   (input valid, input next_pc, input reg_written, input dest_reg,
                   input dest_value, input jump_taken, input memory_stored,
                   output ready);
endinterface

// ----- rtl/tcpu_ram.sv -----
// generic single write port, single registered read port ram
module tcpu_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcpu_regfile.sv -----
// eight-entry register file, two registered read ports, zero until written
module tcpu_regfile (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tcpu_pkg::rf_write_type               wr,
   input  logic                                 rd_en,
   input  logic [tcpu_pkg::REG_IDX_W-1:0]       rd_idx_x,
   input  logic [tcpu_pkg::REG_IDX_W-1:0]       rd_idx_y,
   output logic [tcpu_pkg::DATA_W-1:0]          rd_data_x,
   output logic [tcpu_pkg::DATA_W-1:0]          rd_data_y
);

   logic [tcpu_pkg::REG_COUNT-1:0] valid_ff, valid_in;
   logic                           vx_ff, vx_in;
   logic                           vy_ff, vy_in;
   logic [tcpu_pkg::DATA_W-1:0]    ram_x, ram_y;

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
      vx_in = rd_en ? valid_ff[rd_idx_x] : vx_ff;
      vy_in = rd_en ? valid_ff[rd_idx_y] : vy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vx_ff    <= 1'b0;
         vy_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
      end
   end

   // one copy per read port, both written alike
   tcpu_ram #(.DEPTH(tcpu_pkg::REG_COUNT), .WIDTH(tcpu_pkg::DATA_W)) u_bank_x (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_x),
      .rd_data (ram_x)
   );

   tcpu_ram #(.DEPTH(tcpu_pkg::REG_COUNT), .WIDTH(tcpu_pkg::DATA_W)) u_bank_y (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_y),
      .rd_data (ram_y)
   );

   assign rd_data_x = vx_ff ? ram_x : '0;
   assign rd_data_y = vy_ff ? ram_y : '0;

endmodule

// ----- rtl/tcpu_alu.sv -----
// 16-bit alu: arithmetic, logic, shifts and three-way compare
module tcpu_alu (
   input  tcpu_pkg::alu_op_type          op,
   input  logic [tcpu_pkg::DATA_W-1:0]   a,
   input  logic [tcpu_pkg::DATA_W-1:0]   b,
   output logic [tcpu_pkg::DATA_W-1:0]   res
);

   logic [tcpu_pkg::SHAMT_W-1:0] shamt;

   assign shamt = b[tcpu_pkg::SHAMT_W-1:0];

   always_comb begin
      res = '0;
      unique case (op)
         tcpu_pkg::ALU_ADD: res = a + b;
         tcpu_pkg::ALU_SUB: res = a - b;
         tcpu_pkg::ALU_AND: res = a & b;
         tcpu_pkg::ALU_OR:  res = a | b;
         tcpu_pkg::ALU_XOR: res = a ^ b;
         tcpu_pkg::ALU_SHL: res = a << shamt;
         tcpu_pkg::ALU_SHR: res = a >> shamt;
         tcpu_pkg::ALU_CMP: begin
            if (a == b) begin
               res = tcpu_pkg::CMP_EQ;
            end else if (a > b) begin
               res = tcpu_pkg::CMP_GT;
            end else begin
               res = tcpu_pkg::CMP_LT;
            end
         end
         default: res = '0;
      endcase
   end

endmodule

// ----- rtl/tiny_cpu_execute_unit.sv -----
// top level of the tiny cpu execute unit
//
// use: an instruction fetcher sends one 16-bit instruction word per transfer on
// req_chan, the word stored at the pc reported by the previous result (zero after
// reset). each instruction gives exactly one result transfer on rsp_chan: the next
// pc, the register write-back, whether a jump was taken and whether a store hit
// data memory.
// timing: the req transfer loads the operand stage and the register file read, then
// execute fills the result register, which drives rsp valid. throughput: one
// instruction per cycle while no clearing pass runs and rsp_chan.ready stays high,
// held by the single write port of the register file and the one port pair of the
// data memory; a load followed by a user of its value is fed from the memory read
// register, so no bubbles are inserted.
// reset: synchronous, active high. registers, pc and last alu value read as zero.
// after reset a clearing pass writes zero to every data memory word, one word a
// cycle, and req_chan.ready stays low until the pass is over.
// stall: while rsp_chan.ready is low the result register holds its transfer; one
// more instruction may sit in the operand stage, after which req_chan.ready drops.
module tiny_cpu_execute_unit (
   input logic        clock,
   input logic        reset,
   tcpu_req_if.sink   req_chan,
   tcpu_rsp_if.source rsp_chan
);

   localparam int DW = tcpu_pkg::DATA_W;
   localparam int RW = tcpu_pkg::REG_IDX_W;
   localparam int AW = tcpu_pkg::MEM_ADDR_W;

   // where an operand of the operand stage comes from
   typedef enum logic [1:0] {
      SRC_RF   = 2'd0,
      SRC_FWD  = 2'd1,
      SRC_LOAD = 2'd2
   } src_type;

   // data memory clearing pass
   logic          clr_busy_ff, clr_busy_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // operand stage
   logic          a_valid_ff, a_valid_in;
   logic [DW-1:0] a_ins_ff, a_ins_in;
   src_type       a_src_x_ff, a_src_x_in;
   src_type       a_src_y_ff, a_src_y_in;
   logic [DW-1:0] a_fwd_x_ff, a_fwd_x_in;
   logic [DW-1:0] a_fwd_y_ff, a_fwd_y_in;

   // architectural state outside the files
   logic [DW-1:0] pc_ff, pc_in;
   logic [DW-1:0] last_alu_ff, last_alu_in;

   // result register, also the write-back source
   logic          b_valid_ff, b_valid_in;
   logic [DW-1:0] b_pc_ff, b_pc_in;
   logic          b_wr_ff, b_wr_in;
   logic [RW-1:0] b_dst_ff, b_dst_in;
   logic [DW-1:0] b_val_ff, b_val_in;
   logic          b_ld_ff, b_ld_in;
   logic          b_jmp_ff, b_jmp_in;
   logic          b_st_ff, b_st_in;
   logic          wb_pend_ff, wb_pend_in;

   // handshake
   logic req_xfer;
   logic a_adv;

   // decode of the operand stage
   tcpu_pkg::fmt_type a_fmt;
   logic [RW-1:0]     a_rx;
   logic              a_is_alu, a_is_load, a_is_store, a_writes;
   logic [DW-1:0]     op_x, op_y, alu_b, alu_res;
   logic              jump_hit;
   logic [DW-1:0]     next_pc;
   logic [AW-1:0]     dmem_addr;

   // incoming instruction register indexes
   logic [RW-1:0] req_rx, req_ry;

   logic [DW-1:0] rf_x, rf_y;
   logic [DW-1:0] dmem_rdata;
   logic [DW-1:0] wb_value;
   tcpu_pkg::rf_write_type rf_wr;

   // ---------------------------------------------------------------
   // handshake: the operand stage moves on when the result register
   // is free or is being emptied in this cycle
   // ---------------------------------------------------------------
   assign a_adv          = a_valid_ff && (!b_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clr_busy_ff && (!a_valid_ff || a_adv);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------
   // clearing pass over the data memory after reset
   // ---------------------------------------------------------------
   always_comb begin
      clr_busy_in = clr_busy_ff && (clr_addr_ff != AW'(tcpu_pkg::MEM_WORDS - 1));
      clr_addr_in = clr_busy_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
   end

   // ---------------------------------------------------------------
   // operand stage decode and execute
   // ---------------------------------------------------------------
   assign a_fmt      = tcpu_pkg::fmt_type'(a_ins_ff[1:0]);
   assign a_rx       = a_ins_ff[15:13];
   assign a_is_alu   = (a_fmt == tcpu_pkg::FMT_ALU_REG) || (a_fmt == tcpu_pkg::FMT_ALU_IMM);
   assign a_is_load  = (a_fmt == tcpu_pkg::FMT_MEM) && !a_ins_ff[2];
   assign a_is_store = (a_fmt == tcpu_pkg::FMT_MEM) && a_ins_ff[2];
   assign a_writes   = a_is_alu || a_is_load;

   // operand select: register file, forwarded value, or the load just read
   always_comb begin
      case (a_src_x_ff)
         SRC_FWD:  op_x = a_fwd_x_ff;
         SRC_LOAD: op_x = dmem_rdata;
         default:  op_x = rf_x;
      endcase
      case (a_src_y_ff)
         SRC_FWD:  op_y = a_fwd_y_ff;
         SRC_LOAD: op_y = dmem_rdata;
         default:  op_y = rf_y;
      endcase
   end

   // immediate form replaces the second register with bits 12:5
   assign alu_b = (a_fmt == tcpu_pkg::FMT_ALU_IMM) ? DW'(a_ins_ff[12:5]) : op_y;

   tcpu_alu u_alu (
      .op  (tcpu_pkg::alu_op_type'(a_ins_ff[4:2])),
      .a   (op_x),
      .b   (alu_b),
      .res (alu_res)
   );

   // jump when the condition matches the last alu result
   assign jump_hit = (a_fmt == tcpu_pkg::FMT_JUMP) && (last_alu_ff == DW'(a_ins_ff[3:2]));
   assign next_pc  = jump_hit ? DW'(a_ins_ff[15:4]) : pc_ff + DW'(1);

   // memory address wraps on the memory size
   assign dmem_addr = op_y[AW-1:0];

   // ---------------------------------------------------------------
   // write-back: value of the instruction that entered the result
   // register at the last edge
   // ---------------------------------------------------------------
   assign wb_value   = b_ld_ff ? dmem_rdata : b_val_ff;
   assign rf_wr.en   = wb_pend_ff && b_wr_ff;
   assign rf_wr.idx  = b_dst_ff;
   assign rf_wr.data = wb_value;

   // ---------------------------------------------------------------
   // operand capture with forwarding from the two older instructions
   // still in flight (youngest first)
   // ---------------------------------------------------------------
   assign req_rx = req_chan.instruction[15:13];
   assign req_ry = req_chan.instruction[12:10];

   always_comb begin
      a_valid_in = a_valid_ff;
      a_ins_in   = a_ins_ff;
      a_src_x_in = a_src_x_ff;
      a_src_y_in = a_src_y_ff;
      a_fwd_x_in = a_fwd_x_ff;
      a_fwd_y_in = a_fwd_y_ff;
      if (req_xfer) begin
         a_valid_in = 1'b1;
         a_ins_in   = req_chan.instruction;
         a_src_x_in = SRC_RF;
         a_src_y_in = SRC_RF;
         a_fwd_x_in = wb_value;
         a_fwd_y_in = wb_value;
         // first operand
         if (a_valid_ff && a_writes && (a_rx == req_rx)) begin
            if (a_is_load) begin
               a_src_x_in = SRC_LOAD;
            end else begin
               a_src_x_in = SRC_FWD;
               a_fwd_x_in = alu_res;
            end
         end else if (rf_wr.en && (b_dst_ff == req_rx)) begin
            a_src_x_in = SRC_FWD;
         end
         // second operand
         if (a_valid_ff && a_writes && (a_rx == req_ry)) begin
            if (a_is_load) begin
               a_src_y_in = SRC_LOAD;
            end else begin
               a_src_y_in = SRC_FWD;
               a_fwd_y_in = alu_res;
            end
         end else if (rf_wr.en && (b_dst_ff == req_ry)) begin
            a_src_y_in = SRC_FWD;
         end
      end else if (a_adv) begin
         a_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // pc, last alu value and result register
   // ---------------------------------------------------------------
   always_comb begin
      pc_in       = pc_ff;
      last_alu_in = last_alu_ff;
      b_valid_in  = b_valid_ff;
      b_pc_in     = b_pc_ff;
      b_wr_in     = b_wr_ff;
      b_dst_in    = b_dst_ff;
      b_val_in    = b_val_ff;
      b_ld_in     = b_ld_ff;
      b_jmp_in    = b_jmp_ff;
      b_st_in     = b_st_ff;
      wb_pend_in  = a_adv;
      if (a_adv) begin
         pc_in      = next_pc;
         b_valid_in = 1'b1;
         b_pc_in    = next_pc;
         b_wr_in    = a_writes;
         b_dst_in   = a_writes ? a_rx : '0;
         b_val_in   = a_is_alu ? alu_res : '0;
         b_ld_in    = a_is_load;
         b_jmp_in   = jump_hit;
         b_st_in    = a_is_store;
         if (a_is_alu) begin
            last_alu_in = alu_res;
         end
      end else if (rsp_chan.ready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         a_valid_ff  <= 1'b0;
         a_src_x_ff  <= SRC_RF;
         a_src_y_ff  <= SRC_RF;
         pc_ff       <= '0;
         last_alu_ff <= '0;
         b_valid_ff  <= 1'b0;
         wb_pend_ff  <= 1'b0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         a_valid_ff  <= a_valid_in;
         a_src_x_ff  <= a_src_x_in;
         a_src_y_ff  <= a_src_y_in;
         pc_ff       <= pc_in;
         last_alu_ff <= last_alu_in;
         b_valid_ff  <= b_valid_in;
         wb_pend_ff  <= wb_pend_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      a_ins_ff   <= a_ins_in;
      a_fwd_x_ff <= a_fwd_x_in;
      a_fwd_y_ff <= a_fwd_y_in;
      b_pc_ff    <= b_pc_in;
      b_wr_ff    <= b_wr_in;
      b_dst_ff   <= b_dst_in;
      b_val_ff   <= b_val_in;
      b_ld_ff    <= b_ld_in;
      b_jmp_ff   <= b_jmp_in;
      b_st_ff    <= b_st_in;
   end

   // ---------------------------------------------------------------
   // storage
   // ---------------------------------------------------------------
   tcpu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr        (rf_wr),
      .rd_en     (req_xfer),
      .rd_idx_x  (req_rx),
      .rd_idx_y  (req_ry),
      .rd_data_x (rf_x),
      .rd_data_y (rf_y)
   );

   // clearing pass and stores share the write port; loads read on the way out
   tcpu_ram #(.DEPTH(tcpu_pkg::MEM_WORDS), .WIDTH(DW)) u_dmem (
      .clock   (clock),
      .wr_en   (clr_busy_ff || (a_adv && a_is_store)),
      .wr_addr (clr_busy_ff ? clr_addr_ff : dmem_addr),
      .wr_data (clr_busy_ff ? '0 : op_x),
      .rd_en   (a_adv && a_is_load),
      .rd_addr (dmem_addr),
      .rd_data (dmem_rdata)
   );

   // ---------------------------------------------------------------
   // result channel
   // ---------------------------------------------------------------
   assign rsp_chan.valid         = b_valid_ff;
   assign rsp_chan.next_pc       = b_pc_ff;
   assign rsp_chan.reg_written   = b_wr_ff;
   assign rsp_chan.dest_reg      = b_dst_ff;
   assign rsp_chan.dest_value    = wb_value;
   assign rsp_chan.jump_taken    = b_jmp_ff;
   assign rsp_chan.memory_stored = b_st_ff;

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the tiny cpu execute unit
`timescale 1ns / 100ps

module tb_top;

   localparam int DW = tcpu_pkg::DATA_W;
   localparam int RW = tcpu_pkg::REG_IDX_W;
   localparam int AW = tcpu_pkg::MEM_ADDR_W;
   localparam int SW = tcpu_pkg::SHAMT_W;
   localparam int IW = tcpu_pkg::IMM_W;
   localparam int TW = tcpu_pkg::TARGET_W;

   localparam int RANDOM_ITEMS   = 1350;
   // the clearing pass alone keeps the channels quiet, so the limit is a multiple of MEM_WORDS
   localparam int WATCHDOG_LIMIT = 5 * tcpu_pkg::MEM_WORDS;
   localparam int DRAIN_CYCLES   = 20;
   localparam int MAX_GAP        = 17;

   // one result transfer as the block reports it
   typedef struct packed {
      logic [DW-1:0] next_pc;
      logic          reg_written;
      logic [RW-1:0] dest_reg;
      logic [DW-1:0] dest_value;
      logic          jump_taken;
      logic          memory_stored;
   } retire_type;

   // --------------------------------------------------------------------------
   // scoreboard: a model of the machine state plus the queue of pending results
   // --------------------------------------------------------------------------
   class retire_checker;
      logic [DW-1:0] regs [tcpu_pkg::REG_COUNT];
      logic [DW-1:0] pc;
      logic [DW-1:0] last_alu;
      logic [DW-1:0] dmem [tcpu_pkg::MEM_WORDS];
      retire_type    pending_results [$];
      int unsigned   mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (dmem[i]) dmem[i] = '0;
         pc         = '0;
         last_alu   = '0;
         mismatches = 0;
      endfunction

      function logic [DW-1:0] alu_result(tcpu_pkg::alu_op_type op, logic [DW-1:0] a,
                                         logic [DW-1:0] b);
         logic [SW-1:0] shamt;
         shamt = b[SW-1:0];
         case (op)
            tcpu_pkg::ALU_ADD: return a + b;
            tcpu_pkg::ALU_SUB: return a - b;
            tcpu_pkg::ALU_AND: return a & b;
            tcpu_pkg::ALU_OR:  return a | b;
            tcpu_pkg::ALU_XOR: return a ^ b;
            tcpu_pkg::ALU_SHL: return a << shamt;
            tcpu_pkg::ALU_SHR: return a >> shamt;
            default: return (a == b) ? tcpu_pkg::CMP_EQ :
                            ((a > b) ? tcpu_pkg::CMP_GT : tcpu_pkg::CMP_LT);
         endcase
      endfunction

      // runs one instruction on the model and queues the result it must give
      function void note_instruction(logic [DW-1:0] word);
         retire_type        res;
         tcpu_pkg::fmt_type fmt;
         logic [RW-1:0]     rx;
         logic [RW-1:0]     ry;
         logic [DW-1:0]     operand_b;
         logic [DW-1:0]     value;
         logic [AW-1:0]     addr;
         fmt       = tcpu_pkg::fmt_type'(word[1:0]);
         rx        = word[15:13];
         ry        = word[12:10];
         res       = '0;
         res.next_pc = pc + DW'(1);
         case (fmt) inside
            tcpu_pkg::FMT_ALU_REG, tcpu_pkg::FMT_ALU_IMM: begin
               operand_b = (fmt == tcpu_pkg::FMT_ALU_REG) ? regs[ry] : DW'(word[12:5]);
               value     = alu_result(tcpu_pkg::alu_op_type'(word[4:2]), regs[rx],
                                      operand_b);
               regs[rx]  = value;
               last_alu  = value;
               res.reg_written = 1'b1;
               res.dest_reg    = rx;
               res.dest_value  = value;
            end
            tcpu_pkg::FMT_JUMP: begin
               // last alu value above 3 can never equal the 2-bit condition
               if (DW'(word[3:2]) == last_alu) begin
                  res.next_pc    = DW'(word[15:4]);
                  res.jump_taken = 1'b1;
               end
            end
            default: begin
               addr = regs[ry][AW-1:0];
               if (word[2]) begin
                  dmem[addr]        = regs[rx];
                  res.memory_stored = 1'b1;
               end else begin
                  // loads leave the last alu value alone
                  value           = dmem[addr];
                  regs[rx]        = value;
                  res.reg_written = 1'b1;
                  res.dest_reg    = rx;
                  res.dest_value  = value;
               end
            end
         endcase
         pc = res.next_pc;
         pending_results.insert(pending_results.size(), res);
      endfunction

      function void compare_field(string name, logic [DW-1:0] want,
                                  logic [DW-1:0] got);
         if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_result(retire_type got);
         retire_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with none pending, expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = pending_results.pop_front();
         compare_field("next_pc",       want.next_pc,           got.next_pc);
         compare_field("reg_written",   DW'(want.reg_written),   DW'(got.reg_written));
         compare_field("dest_reg",      DW'(want.dest_reg),      DW'(got.dest_reg));
         compare_field("dest_value",    want.dest_value,        got.dest_value);
         compare_field("jump_taken",    DW'(want.jump_taken),    DW'(got.jump_taken));
         compare_field("memory_stored", DW'(want.memory_stored), DW'(got.memory_stored));
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // clock, reset, channels and the block
   // --------------------------------------------------------------------------
   logic clock;
   logic reset;

   tcpu_req_if req_chan ();
   tcpu_rsp_if rsp_chan ();

   tiny_cpu_execute_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   retire_checker scoreboard;
   int            idle_cycles;
   bit            tx_calm;
   bit            rx_calm;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // instruction encoders, unused bits filled at random
   // --------------------------------------------------------------------------
   function logic [DW-1:0] enc_alu_reg(tcpu_pkg::alu_op_type op, logic [2:0] rx,
                                       logic [2:0] ry);
      logic [4:0] spare;
      spare = 5'($urandom);
      return {rx, ry, spare, op, tcpu_pkg::FMT_ALU_REG};
   endfunction

   function logic [DW-1:0] enc_alu_imm(tcpu_pkg::alu_op_type op, logic [2:0] rx,
                                       logic [IW-1:0] imm);
      return {rx, imm, op, tcpu_pkg::FMT_ALU_IMM};
   endfunction

   function logic [DW-1:0] enc_jump(logic [TW-1:0] target, logic [1:0] cond);
      return {target, cond, tcpu_pkg::FMT_JUMP};
   endfunction

   function logic [DW-1:0] enc_mem(logic store, logic [2:0] rx, logic [2:0] ry);
      logic [6:0] spare;
      spare = 7'($urandom);
      return {rx, ry, spare, store, tcpu_pkg::FMT_MEM};
   endfunction

   // --------------------------------------------------------------------------
   // sender: optional gap, then hold valid until the transfer
   // --------------------------------------------------------------------------
   task automatic send_word(logic [DW-1:0] word);
      int gap;
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.instruction <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // holds off the sender until every pending result has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // random stimulus: mostly short well-formed sequences with random content
   // --------------------------------------------------------------------------
   task automatic send_random_group(inout int sent);
      int          kind;
      logic [2:0]  ra;
      logic [2:0]  rb;
      kind = $urandom_range(0, 99);
      ra   = 3'($urandom);
      rb   = 3'($urandom);
      if (kind < 12) begin
         // raw noise, every bit pattern possible
         send_word(DW'($urandom));
         sent += 1;
      end else if (kind < 40) begin
         send_word(enc_alu_reg(tcpu_pkg::alu_op_type'($urandom_range(0, 7)), ra, rb));
         sent += 1;
      end else if (kind < 62) begin
         send_word(enc_alu_imm(tcpu_pkg::alu_op_type'($urandom_range(0, 7)), ra,
                               IW'($urandom)));
         sent += 1;
      end else if (kind < 78) begin
         // compare then a jump on its outcome, often taken
         if ($urandom_range(0, 1))
            send_word(enc_alu_reg(tcpu_pkg::ALU_CMP, ra, rb));
         else
            send_word(enc_alu_imm(tcpu_pkg::ALU_CMP, ra, IW'($urandom)));
         send_word(enc_jump(TW'($urandom), 2'($urandom_range(0, 3))));
         sent += 2;
      end else if (kind < 86) begin
         send_word(enc_jump(TW'($urandom), 2'($urandom)));
         sent += 1;
      end else if (kind < 95) begin
         // store then load back through the same address register
         send_word(enc_mem(1'b1, ra, rb));
         send_word(enc_mem(1'b0, 3'($urandom), rb));
         sent += 2;
      end else begin
         send_word(enc_mem(1'($urandom), ra, rb));
         sent += 1;
      end
   endtask

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin
      int sent;
      scoreboard           = new();
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.instruction = '0;
      tx_calm              = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed part: operand extremes, every alu op, jumps and memory corners
      send_word(16'h0000);                                      // add r0, r0 on all-zero word
      send_word(enc_alu_imm(tcpu_pkg::ALU_ADD, 3'd0, 8'hFF));
      send_word(enc_alu_imm(tcpu_pkg::ALU_SHL, 3'd0, 8'h08));   // r0 = ff00
      send_word(enc_alu_imm(tcpu_pkg::ALU_OR,  3'd0, 8'hFF));   // r0 = ffff
      send_word(enc_alu_imm(tcpu_pkg::ALU_ADD, 3'd1, 8'h01));
      send_word(enc_alu_reg(tcpu_pkg::ALU_ADD, 3'd0, 3'd1));    // wraps to zero
      send_word(enc_alu_reg(tcpu_pkg::ALU_SUB, 3'd0, 3'd1));    // wraps to ffff
      send_word(enc_alu_reg(tcpu_pkg::ALU_AND, 3'd0, 3'd1));
      send_word(enc_alu_imm(tcpu_pkg::ALU_XOR, 3'd7, 8'hAA));
      send_word(enc_alu_reg(tcpu_pkg::ALU_XOR, 3'd7, 3'd7));
      send_word(enc_alu_imm(tcpu_pkg::ALU_OR,  3'd2, 8'hF0));
      // shift amount from the low four immediate bits only
      send_word(enc_alu_imm(tcpu_pkg::ALU_SHL, 3'd2, 8'hF4));
      send_word(enc_alu_reg(tcpu_pkg::ALU_SHR, 3'd2, 3'd1));
      send_word(enc_alu_reg(tcpu_pkg::ALU_CMP, 3'd2, 3'd1));    // greater
      send_word(enc_jump(12'hFFF, 2'd1));                       // taken to the top target
      send_word(enc_alu_reg(tcpu_pkg::ALU_CMP, 3'd1, 3'd2));    // less
      send_word(enc_jump(12'h5A5, 2'd1));                       // not taken
      send_word(enc_alu_reg(tcpu_pkg::ALU_CMP, 3'd1, 3'd1));    // equal
      send_word(enc_jump(12'h000, 2'd0));                       // taken to zero
      send_word(enc_alu_imm(tcpu_pkg::ALU_OR,  3'd3, 8'hFF));   // last alu value above 3
      send_word(enc_jump(12'h123, 2'd3));                       // cannot match
      send_word(enc_alu_imm(tcpu_pkg::ALU_SUB, 3'd4, 8'h01));   // r4 = ffff, address wraps
      send_word(enc_mem(1'b1, 3'd3, 3'd4));
      send_word(enc_alu_imm(tcpu_pkg::ALU_CMP, 3'd1, 8'h01));   // last alu value zero
      send_word(enc_mem(1'b0, 3'd5, 3'd4));                     // load keeps last alu value
      send_word(enc_jump(12'h0F0, 2'd0));                       // still taken after the load
      send_word(enc_mem(1'b0, 3'd6, 3'd1));                     // word untouched since reset
      send_word(16'hFFFF);                                      // store r7 at r7
      drain_results();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         send_random_group(sent);
         if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 2) drain_results();
      end
      req_chan.valid <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0)
         $display("tiny_cpu_execute_unit test passed");
      else
         $display("tiny_cpu_execute_unit test failed");
      $finish;
   end

   // --------------------------------------------------------------------------
   // receiver: random back-pressure, with calm stretches
   // --------------------------------------------------------------------------
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      rx_calm        = 1'b0;
      repeat (11) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
         gap = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
      end
   end

   // --------------------------------------------------------------------------
   // monitors: every transfer on either channel goes to the scoreboard
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      retire_type got;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            scoreboard.note_instruction(req_chan.instruction);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.next_pc       = rsp_chan.next_pc;
            got.reg_written   = rsp_chan.reg_written;
            got.dest_reg      = rsp_chan.dest_reg;
            got.dest_value    = rsp_chan.dest_value;
            got.jump_taken    = rsp_chan.jump_taken;
            got.memory_stored = rsp_chan.memory_stored;
            scoreboard.check_result(got);
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tiny_cpu_execute_unit test failed");
         $finish;
      end
   end

endmodule
